@@ hdl/mwpo_pkg.sv @@
//------------------------------------------------------------------------------
// mwpo_pkg: shared types and constants for the polyBLEP oscillator
// Register indexes, waveform codes, item kinds and reset values.
//------------------------------------------------------------------------------
`default_nettype none

package mwpo_pkg;

  localparam int unsigned SineTableDepthDefault = 1024;
  localparam int unsigned PhaseBitsDefault      = 32;

  typedef enum logic [2:0] {
    REG_WAVEFORM   = 3'd0,
    REG_LFO_MODE   = 3'd1,
    REG_PHASE_STEP = 3'd2,
    REG_START      = 3'd3,
    REG_SYNC       = 3'd4,
    REG_PULSE_W    = 3'd5,
    REG_SH_PERIOD  = 3'd6,
    REG_VOLUME     = 3'd7
  } reg_idx_e;

  typedef enum logic [3:0] {
    WAVE_SINE     = 4'd0,
    WAVE_BLEP_SAW = 4'd1,
    WAVE_TRI      = 4'd2,
    WAVE_BLEP_PUL = 4'd3,
    WAVE_BLEP_SQR = 4'd4,
    WAVE_NOISE    = 4'd5,
    WAVE_SH       = 4'd6,
    WAVE_SAW      = 4'd7,
    WAVE_SQR      = 4'd8
  } wave_e;

  typedef enum logic [1:0] {
    KIND_SAMPLE  = 2'd0,
    KIND_TRIGGER = 2'd1,
    KIND_STOP    = 2'd2,
    KIND_NONE    = 2'd3
  } kind_e;

  localparam logic [31:0] NoiseASeed     = 32'h6745_2301;
  localparam logic [31:0] NoiseCSeed     = 32'hefcd_ab89;
  localparam logic [31:0] PhaseStepReset = 32'd42852282;
  localparam logic [31:0] PulseWReset    = 32'h8000_0000;
  localparam logic [15:0] ShPeriodReset  = 16'd44;
  localparam logic [15:0] VolumeReset    = 16'd32768;
  localparam logic [63:0] HalfPiQ30      = 64'd1686629713;

  // Quarter-wave sine entry i of a table of depth n, Q15, Q30 Taylor series.
  // Evaluated at elaboration only.
  function automatic logic [15:0] sine_entry(input int unsigned i, input int unsigned n);
    logic [63:0] x;
    logic [63:0] x2;
    logic [63:0] term;
    longint      sum;
    begin
      x    = (64'(i) * HalfPiQ30) / 64'(n);
      x2   = (x * x) >> 30;
      term = x;
      sum  = longint'(x);
      for (int k = 1; k <= 8; k++) begin
        term = ((term * x2) >> 30) / 64'((2 * k) * (2 * k + 1));
        if (k % 2 == 1) sum = sum - longint'(term);
        else            sum = sum + longint'(term);
      end
      if (sum < 0) sum = 0;
      sum = (sum + 16384) / 32768;
      if (sum > 32768) sum = 32768;
      return 16'(sum);
    end
  endfunction

endpackage

`default_nettype wire

@@ hdl/mwpo_div.sv @@
//------------------------------------------------------------------------------
// mwpo_div: restoring divider for the polyBLEP fraction
// Computes (t << 15) / dt for t < dt, one quotient bit a cycle.
//------------------------------------------------------------------------------
`default_nettype none

module mwpo_div (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [31:0] num_i,   // t, always below den_i
  input  logic [31:0] den_i,
  output logic        done_o,
  output logic [15:0] quot_o   // at most 32767
);
  import mwpo_pkg::*;

  logic [32:0] rem_q, rem_d;
  logic [14:0] quo_q, quo_d;
  logic [3:0]  cnt_q, cnt_d;
  logic        busy_q, busy_d;
  logic [32:0] shifted;
  logic [32:0] diff;

  assign shifted = {rem_q[31:0], 1'b0};
  assign diff    = shifted - {1'b0, den_i};

  always_comb begin
    rem_d  = rem_q;
    quo_d  = quo_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_o = 1'b0;
    if (start_i) begin
      rem_d  = {1'b0, num_i};
      cnt_d  = 4'd0;
      busy_d = 1'b1;
    end else if (busy_q) begin
      if (!diff[32]) begin
        rem_d = diff;
        quo_d = {quo_q[13:0], 1'b1};
      end else begin
        rem_d = shifted;
        quo_d = {quo_q[13:0], 1'b0};
      end
      cnt_d = cnt_q + 4'd1;
      if (cnt_q == 4'd14) begin
        busy_d = 1'b0;
      end
    end
    if (!busy_q && !start_i && cnt_q == 4'd15) begin
      done_o = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= 4'd0;
    end else begin
      busy_q <= busy_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
  end

  assign quot_o = {1'b0, quo_q};

endmodule

`default_nettype wire

@@ hdl/multiwave_polyblep_oscillator_core.sv @@
//------------------------------------------------------------------------------
// multiwave_polyblep_oscillator_core: phase-accumulator oscillator
// Sine, saw, triangle, pulse, square (raw or polyBLEP), noise, sample & hold.
//------------------------------------------------------------------------------
// Path, accept to out_valid: inactive sample straight to ST_OUT; raw waves and
// noise via ST_MULV; sine adds ST_SINE, LFO mode ST_LFO; blep waves add ST_BLEP
// per edge check and ST_DIV (serial divide), ST_SQ1 and an ST_OUT fold per
// corrected edge. One item at a time, the next taken the cycle after the result
// loads; trigger, stop and unknown kinds end at accept. A result not yet taken
// stalls the sequencer in its last state. Reset: documented values, inactive.
`default_nettype none

module multiwave_polyblep_oscillator_core #(
  parameter int unsigned SINE_TABLE_DEPTH = mwpo_pkg::SineTableDepthDefault,
  parameter int unsigned PHASE_BITS       = mwpo_pkg::PhaseBitsDefault
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [2:0]         cfg_index_i,
  input  logic [31:0]        cfg_data_i,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [1:0]         kind_i,
  input  logic signed [15:0] pitch_mod_i,
  input  logic [31:0]        pw_offset_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic signed [16:0] sample_o
);
  import mwpo_pkg::*;

  localparam int unsigned IdxBits = $clog2(SINE_TABLE_DEPTH);
  localparam logic [31:0] PhaseMask = ~((32'd1 << (32 - PHASE_BITS)) - 32'd1);

  typedef enum logic [7:0] {
    ST_IDLE  = 8'b00000001,
    ST_SINE  = 8'b00000010, // registered table entry ready
    ST_BLEP  = 8'b00000100, // classify t against dt, start divide
    ST_DIV   = 8'b00001000, // wait for divider
    ST_SQ1   = 8'b00010000, // square (1-u)^2 with shared multiplier
    ST_MULV  = 8'b00100000, // value * volume
    ST_LFO   = 8'b01000000, // step * (1+pm)
    ST_OUT   = 8'b10000000  // saturate, register result
  } state_e;

  // Sine table, evaluated at elaboration, read through a register.
  logic [15:0] sine_rom [SINE_TABLE_DEPTH+1];
  for (genvar g = 0; g <= SINE_TABLE_DEPTH; g++) begin : g_rom
    assign sine_rom[g] = sine_entry(g, SINE_TABLE_DEPTH);
  end

  // Configuration.
  logic [3:0]  waveform_q;
  logic        lfo_q, sync_q;
  logic [31:0] step_q, start_q, pw_q;
  logic [15:0] shp_q, vol_q;

  // Oscillator state.
  logic [31:0]        phase_q, na_q, nc_q;
  logic signed [17:0] held_q;
  logic signed [17:0] hold_cnt_q;
  logic               run_q;

  // Sequencer.
  state_e             st_q;
  logic signed [18:0] val_q;      // running waveform value
  logic [1:0]         nblep_q;    // bleps still to apply
  logic [31:0]        t_q;        // blep argument
  logic               neg_q;      // blep sign (t < dt gives negative)
  logic               sub_q;      // subtract blep from value
  logic signed [16:0] pm_q;
  logic signed [50:0] prod_q;     // shared multiplier output
  logic [16:0]        u_q;
  logic signed [16:0] out_q;
  logic               out_v_q;
  logic [15:0]        sraw_q;     // table entry for the current phase

  // Shared multiplier: 34 x 17 signed, one use per state.
  logic signed [33:0] mul_a;
  logic signed [16:0] mul_b;
  logic signed [50:0] mul_p;
  assign mul_p = mul_a * mul_b;

  logic        div_start, div_done;
  logic [15:0] div_q;
  mwpo_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (t_q),
    .den_i   (step_q),
    .done_o  (div_done),
    .quot_o  (div_q)
  );

  // Input is free whenever the sequencer is idle; a waiting result only
  // holds ST_OUT.
  logic accept_in, accept_cfg;
  assign in_ready_o  = (st_q == ST_IDLE);
  assign accept_in   = in_valid_i && in_ready_o;
  assign cfg_ready_o = 1'b1;
  assign accept_cfg  = cfg_valid_i;
  assign out_valid_o = out_v_q;
  assign sample_o    = out_q;

  // Combinational waveform base at item accept.
  logic signed [18:0] saw, sq, tri_v, sine_v, noise_v, pul_v;
  logic [31:0]        pq, na_n, nc_n;
  logic [IdxBits:0]   sidx;
  logic [IdxBits:0]   saddr;
  logic [32:0]        tneg;
  always_comb begin
    saw   = 19'(signed'({1'b0, phase_q[31:16]})) - 19'sd32768;
    sq    = phase_q[31] ? -19'sd32768 : 19'sd32768;
    tri_v = ((saw < 0) ? -(saw <<< 1) : (saw <<< 1)) - 19'sd32768;
    pq    = phase_q + pw_q + pw_offset_i;
    pul_v = 19'sd32768 - 19'(signed'({1'b0, pq[31:16]}));
    sidx  = (IdxBits+1)'(({2'b00, phase_q[29:0]} * 64'(SINE_TABLE_DEPTH)) >> 30);
    saddr = phase_q[30] ? (IdxBits+1)'(SINE_TABLE_DEPTH) - sidx : sidx;
    sine_v  = phase_q[31] ? -19'(signed'({1'b0, sraw_q})) : 19'(signed'({1'b0, sraw_q}));
    na_n    = na_q ^ nc_q;
    nc_n    = nc_q + na_n;
    noise_v = 19'(signed'(nc_q[31:16]));
    tneg    = 33'h1_0000_0000 - {1'b0, t_q};
  end

  always_ff @(posedge clk_i) begin
    sraw_q <= sine_rom[saddr];
  end

  // Multiplier operand select.
  logic [16:0] one_minus_u;
  assign one_minus_u = 17'd32768 - u_q;
  always_comb begin
    mul_a = 34'(val_q);
    mul_b = 17'(signed'({1'b0, vol_q}));
    unique case (st_q)
      ST_SQ1: begin
        mul_a = 34'(signed'({1'b0, one_minus_u}));
        mul_b = signed'(one_minus_u);
      end
      ST_LFO: begin
        mul_a = signed'({2'b00, step_q});
        mul_b = 17'sd32768 + pm_q;
      end
      default: begin
      end
    endcase
  end

  logic signed [50:0] res;
  logic signed [18:0] blep_r;
  always_comb begin
    // floor division by 32768
    res    = prod_q >>> 15;
    blep_r = 19'(signed'({1'b0, 17'(prod_q >>> 15)}));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      waveform_q <= 4'd0;
      lfo_q      <= 1'b0;
      step_q     <= PhaseStepReset;
      start_q    <= 32'd0;
      sync_q     <= 1'b1;
      pw_q       <= PulseWReset;
      shp_q      <= ShPeriodReset;
      vol_q      <= VolumeReset;
      phase_q    <= 32'd0;
      na_q       <= NoiseASeed;
      nc_q       <= NoiseCSeed;
      held_q     <= '0;
      hold_cnt_q <= '0;
      run_q      <= 1'b0;
      st_q       <= ST_IDLE;
      out_v_q    <= 1'b0;
      div_start  <= 1'b0;
    end else begin
      div_start <= 1'b0;
      if (out_v_q && out_ready_i) out_v_q <= 1'b0;
      if (accept_cfg) begin
        unique case (reg_idx_e'(cfg_index_i))
          REG_WAVEFORM: begin
            waveform_q <= cfg_data_i[3:0];
            held_q     <= '0;
          end
          REG_LFO_MODE:   lfo_q  <= cfg_data_i[0];
          REG_PHASE_STEP: step_q <= cfg_data_i;
          REG_START:      start_q <= cfg_data_i;
          REG_SYNC:       sync_q <= cfg_data_i[0];
          REG_PULSE_W:    pw_q   <= cfg_data_i;
          REG_SH_PERIOD:  shp_q  <= cfg_data_i[15:0];
          REG_VOLUME:     vol_q  <= cfg_data_i[15:0];
          default: begin
          end
        endcase
      end
      unique case (st_q)
        ST_IDLE: begin
          if (accept_in) begin
            pm_q     <= 17'(pitch_mod_i);
            t_q      <= phase_q;
            nblep_q  <= 2'd0;
            sub_q    <= 1'b1;
            unique case (kind_e'(kind_i))
              KIND_TRIGGER: begin
                if (sync_q) phase_q <= start_q & PhaseMask;
                run_q <= 1'b1;
              end
              KIND_STOP: run_q <= 1'b0;
              KIND_SAMPLE: begin
                if (!run_q) begin
                  // inactive: zero result through the output stage
                  prod_q <= '0;
                  st_q   <= ST_OUT;
                end else begin
                  val_q <= '0;
                  st_q  <= ST_MULV;
                  unique case (waveform_q)
                    WAVE_SINE: st_q <= ST_SINE;
                    WAVE_BLEP_SAW: begin
                      val_q <= saw; nblep_q <= 2'd1; st_q <= ST_BLEP;
                    end
                    WAVE_TRI: val_q <= tri_v;
                    WAVE_BLEP_PUL: begin
                      val_q <= saw + pul_v; nblep_q <= 2'd1; st_q <= ST_BLEP;
                    end
                    WAVE_BLEP_SQR: begin
                      val_q <= sq; nblep_q <= 2'd2; sub_q <= 1'b0;
                      st_q <= ST_BLEP;
                    end
                    WAVE_NOISE: begin
                      val_q <= noise_v; na_q <= na_n; nc_q <= nc_n;
                    end
                    WAVE_SH: begin
                      na_q <= na_n; nc_q <= nc_n;
                      if (hold_cnt_q < 0) begin
                        val_q      <= noise_v;
                        held_q     <= 18'(noise_v);
                        hold_cnt_q <= 18'(signed'({2'b00, shp_q})) - 18'sd1;
                      end else begin
                        val_q      <= 19'(held_q);
                        hold_cnt_q <= hold_cnt_q - 18'sd1;
                      end
                    end
                    WAVE_SAW: val_q <= saw;
                    WAVE_SQR: val_q <= sq;
                    default:  val_q <= '0;
                  endcase
                end
              end
              default: begin
              end
            endcase
          end
        end
        ST_SINE: begin
          val_q <= sine_v;
          st_q  <= ST_MULV;
        end
        ST_BLEP: begin
          // t < dt: negative blep on t; 2^32 - t < dt: positive on 2^32 - t
          if ({1'b0, t_q} < {1'b0, step_q}) begin
            neg_q     <= 1'b1;
            div_start <= 1'b1;
            st_q      <= ST_DIV;
          end else if (tneg < {1'b0, step_q}) begin
            neg_q     <= 1'b0;
            t_q       <= tneg[31:0];
            div_start <= 1'b1;
            st_q      <= ST_DIV;
          end else begin
            nblep_q <= nblep_q - 2'd1;
            t_q     <= phase_q + 32'h8000_0000;
            sub_q   <= 1'b1;
            st_q    <= (nblep_q == 2'd1) ? ST_MULV : ST_BLEP;
          end
        end
        ST_DIV: begin
          if (div_done) begin
            u_q  <= {1'b0, div_q};
            st_q <= ST_SQ1;
          end
        end
        ST_SQ1: begin
          prod_q <= mul_p;
          st_q   <= ST_OUT;
          nblep_q <= nblep_q; // apply in ST_OUT path
        end
        ST_MULV: begin
          prod_q <= mul_p;
          st_q   <= lfo_q ? ST_LFO : ST_OUT;
          if (!lfo_q) phase_q <= (phase_q + step_q) & PhaseMask;
        end
        ST_LFO: begin
          phase_q <= (phase_q + 32'(mul_p >>> 15)) & PhaseMask;
          prod_q  <= prod_q;
          st_q    <= ST_OUT;
          nblep_q <= 2'd3; // marks volume product already in prod_q
        end
        ST_OUT: begin
          if (nblep_q != 2'd0 && nblep_q != 2'd3) begin
            // blep magnitude in prod_q; fold into value, next blep or volume
            if (neg_q ^ sub_q) val_q <= val_q - blep_r;
            else               val_q <= val_q + blep_r;
            nblep_q <= nblep_q - 2'd1;
            t_q     <= phase_q + 32'h8000_0000;
            sub_q   <= 1'b1;
            st_q    <= (nblep_q == 2'd1) ? ST_MULV : ST_BLEP;
          end else if (!out_v_q || out_ready_i) begin
            if (res > 51'sd65535)       out_q <= 17'sd65535;
            else if (res < -51'sd65536) out_q <= -17'sd65536;
            else                        out_q <= 17'(res);
            out_v_q <= 1'b1;
            nblep_q <= 2'd0;
            st_q    <= ST_IDLE;
          end
        end
        default: st_q <= ST_IDLE;
      endcase
    end
  end

endmodule

`default_nettype wire
